@@ hdl/lcdseq_pkg.sv @@
package lcdseq_pkg;

	// one command item and one expander beat
	typedef struct packed {
		logic [3:0] command;
		logic [7:0] value;
		logic [7:0] row;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  expander_byte;
		logic [12:0] wait_after_us;
		logic        last;
	} beat_t;

	typedef enum logic [3:0] {
		CMD_CHAR       = 4'd0,
		CMD_CLEAR      = 4'd1,
		CMD_HOME       = 4'd2,
		CMD_SET_CURSOR = 4'd3,
		CMD_BACKLIGHT  = 4'd4,
		CMD_DISPLAY    = 4'd5,
		CMD_CURSOR_SW  = 4'd6,
		CMD_BLINK      = 4'd7,
		CMD_SCROLL     = 4'd8,
		CMD_TEXTDIR    = 4'd9,
		CMD_AUTOSCROLL = 4'd10,
		CMD_INIT       = 4'd11
	} cmd_code_t;

	typedef enum logic [1:0] {
		JOB_BL,
		JOB_FULL,
		JOB_INIT
	} job_kind_t;

	// job handed from front to back
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
		logic       rs;
		logic       slow;
		logic       bl;
	} job_t;

	typedef enum logic [1:0] {
		WAIT_STD,
		WAIT_SLOW,
		WAIT_MID,
		WAIT_LONG
	} wait_code_t;

	typedef struct packed {
		logic [3:0] nib;
		wait_code_t wcode;
	} init_step_t;

	localparam logic [7:0] BIT_RS     = 8'h01;
	localparam logic [7:0] BIT_EN     = 8'h04;
	localparam logic [7:0] BIT_BL     = 8'h08;
	localparam logic [7:0] OP_CLEAR   = 8'h01;
	localparam logic [7:0] OP_HOME    = 8'h02;
	localparam logic [7:0] OP_ENTRY   = 8'h04;
	localparam logic [7:0] OP_DISPCTL = 8'h08;
	localparam logic [7:0] OP_SHIFT   = 8'h10;
	localparam logic [7:0] OP_DDRAM   = 8'h80;

	localparam logic [2:0] DISP_RESET  = 3'd4;
	localparam logic [1:0] ENTRY_RESET = 2'd2;

	localparam logic [3:0] INIT_LAST = 4'd13;

	localparam logic [12:0] WAIT_SETUP_US = 13'd0;
	localparam logic [12:0] WAIT_EN_US    = 13'd1;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		case (r)
			2'd0:    row_base = 8'h00;
			2'd1:    row_base = 8'h40;
			2'd2:    row_base = 8'h14;
			default: row_base = 8'h54;
		endcase
	endfunction

	function automatic logic [12:0] wait_us(input wait_code_t c);
		case (c)
			WAIT_STD:  wait_us = 13'd50;
			WAIT_SLOW: wait_us = 13'd2050;
			WAIT_MID:  wait_us = 13'd200;
			default:   wait_us = 13'd5050;
		endcase
	endfunction

	// init nibble list: three wake-ups, 4-bit switch, then five full commands
	function automatic init_step_t init_step(input logic [3:0] idx);
		case (idx)
			4'd0:    init_step = '{nib: 4'h3, wcode: WAIT_LONG};
			4'd1:    init_step = '{nib: 4'h3, wcode: WAIT_LONG};
			4'd2:    init_step = '{nib: 4'h3, wcode: WAIT_MID};
			4'd3:    init_step = '{nib: 4'h2, wcode: WAIT_STD};
			4'd4:    init_step = '{nib: 4'h2, wcode: WAIT_STD};
			4'd5:    init_step = '{nib: 4'h8, wcode: WAIT_STD};
			4'd6:    init_step = '{nib: 4'h0, wcode: WAIT_STD};
			4'd7:    init_step = '{nib: 4'hC, wcode: WAIT_STD};
			4'd8:    init_step = '{nib: 4'h0, wcode: WAIT_STD};
			4'd9:    init_step = '{nib: 4'h1, wcode: WAIT_SLOW};
			4'd10:   init_step = '{nib: 4'h0, wcode: WAIT_STD};
			4'd11:   init_step = '{nib: 4'h6, wcode: WAIT_STD};
			4'd12:   init_step = '{nib: 4'h0, wcode: WAIT_STD};
			default: init_step = '{nib: 4'h2, wcode: WAIT_SLOW};
		endcase
	endfunction

endpackage

@@ hdl/char_lcd_i2c_nibble_sequencer_unit.sv @@
// character lcd sequencer for a 4-bit bus behind an i2c port expander. each
// accepted command becomes a run of expander beats: every lcd byte leaves as
// two nibbles, high first, and every nibble as three beats (setup, en high,
// en low) carrying rs and the backlight bit; each beat states the wait in
// microseconds that must follow it, and the final beat of a command has last
// set. the back end issues one beat per cycle when not stalled, so a character
// or lcd command is 6 beats, a backlight command 1 beat and init 42 beats;
// that beat generator sets the rate. the front end takes a new command every
// cycle while the job queue (QUEUE_DEPTH entries) has room, so commands overlap
// the beats of earlier ones. codes 12 to 15 are taken and dropped with no beat
module char_lcd_i2c_nibble_sequencer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  lcdseq_pkg::cmd_t  cmd,
	output logic              beat_valid,
	input  logic              beat_stall,
	output lcdseq_pkg::beat_t beat
);

	// front to queue
	logic             push;
	lcdseq_pkg::job_t push_job;
	logic             q_full;

	// queue to back
	logic             pop;
	logic             head_valid;
	lcdseq_pkg::job_t head_job;

	// front: decodes the command, keeps backlight, display and entry bits
	lcdseq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	// short job queue so either side can stall alone
	lcdseq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// back: walks nibbles and phases, one beat per cycle into the output register unless stalled
	lcdseq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.beat_valid (beat_valid),
		.beat_stall (beat_stall),
		.beat       (beat)
	);

endmodule

@@ hdl/lcdseq_front.sv @@
module lcdseq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  lcdseq_pkg::cmd_t    cmd,
	input  logic                q_full,
	output logic                push,
	output lcdseq_pkg::job_t    job
);

	logic       backlight_q;
	logic [2:0] disp_q;
	logic [1:0] entry_q;

	logic       bl_d;
	logic [2:0] disp_d;
	logic [1:0] entry_d;
	logic       flag;
	logic       is_cmd;
	logic [1:0] row_idx;
	logic       accept;

	assign cmd_stall = q_full;
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = accept && is_cmd;

	always_comb begin
		flag     = cmd.value[0];
		row_idx  = (cmd.row < 8'd4) ? cmd.row[1:0] : 2'd0;
		bl_d     = backlight_q;
		disp_d   = disp_q;
		entry_d  = entry_q;
		is_cmd   = 1'b1;
		job.kind = lcdseq_pkg::JOB_FULL;
		job.data = 8'h00;
		job.rs   = 1'b0;
		job.slow = 1'b0;
		job.bl   = backlight_q;
		unique case (lcdseq_pkg::cmd_code_t'(cmd.command))
			lcdseq_pkg::CMD_CHAR: begin
				job.data = cmd.value;
				job.rs   = 1'b1;
			end
			lcdseq_pkg::CMD_CLEAR: begin
				job.data = lcdseq_pkg::OP_CLEAR;
				job.slow = 1'b1;
			end
			lcdseq_pkg::CMD_HOME: begin
				job.data = lcdseq_pkg::OP_HOME;
				job.slow = 1'b1;
			end
			lcdseq_pkg::CMD_SET_CURSOR: begin
				job.data = lcdseq_pkg::OP_DDRAM | (cmd.value + lcdseq_pkg::row_base(row_idx));
			end
			lcdseq_pkg::CMD_BACKLIGHT: begin
				bl_d     = flag;
				job.kind = lcdseq_pkg::JOB_BL;
				job.bl   = flag;
			end
			lcdseq_pkg::CMD_DISPLAY: begin
				disp_d[2] = flag;
				job.data  = lcdseq_pkg::OP_DISPCTL | {5'd0, disp_d};
			end
			lcdseq_pkg::CMD_CURSOR_SW: begin
				disp_d[1] = flag;
				job.data  = lcdseq_pkg::OP_DISPCTL | {5'd0, disp_d};
			end
			lcdseq_pkg::CMD_BLINK: begin
				disp_d[0] = flag;
				job.data  = lcdseq_pkg::OP_DISPCTL | {5'd0, disp_d};
			end
			lcdseq_pkg::CMD_SCROLL: begin
				job.data = lcdseq_pkg::OP_SHIFT | 8'h08 | (flag ? 8'h00 : 8'h04);
			end
			lcdseq_pkg::CMD_TEXTDIR: begin
				entry_d[1] = flag;
				job.data   = lcdseq_pkg::OP_ENTRY | {6'd0, entry_d};
			end
			lcdseq_pkg::CMD_AUTOSCROLL: begin
				entry_d[0] = flag;
				job.data   = lcdseq_pkg::OP_ENTRY | {6'd0, entry_d};
			end
			lcdseq_pkg::CMD_INIT: begin
				job.kind = lcdseq_pkg::JOB_INIT;
				disp_d   = lcdseq_pkg::DISP_RESET;
				entry_d  = lcdseq_pkg::ENTRY_RESET;
			end
			default: begin
				is_cmd = 1'b0;
			end
		endcase
	end

	// unused codes leave the state alone (the defaults above hold it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
			disp_q      <= lcdseq_pkg::DISP_RESET;
			entry_q     <= lcdseq_pkg::ENTRY_RESET;
		end else if (accept) begin
			backlight_q <= bl_d;
			disp_q      <= disp_d;
			entry_q     <= entry_d;
		end
	end

endmodule

@@ hdl/lcdseq_queue.sv @@
module lcdseq_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcdseq_pkg::job_t  push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output lcdseq_pkg::job_t  head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lcdseq_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/lcdseq_back.sv @@
module lcdseq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  lcdseq_pkg::job_t  head_job,
	output logic              pop,
	output logic              beat_valid,
	input  logic              beat_stall,
	output lcdseq_pkg::beat_t beat
);

	typedef enum logic [1:0] {
		PH_SETUP,
		PH_EN_HIGH,
		PH_EN_LOW
	} phase_t;

	logic              busy_q;
	lcdseq_pkg::job_t  job_q;
	logic [3:0]        nib_q;
	phase_t            phase_q;
	logic              beat_valid_q;
	lcdseq_pkg::beat_t beat_q;

	lcdseq_pkg::beat_t      cur;
	lcdseq_pkg::init_step_t istep;
	lcdseq_pkg::wait_code_t wcode;
	logic [3:0]             nib;
	logic                   final_nib;
	logic [7:0]             base;
	logic                   adv;

	assign adv        = !beat_valid_q || !beat_stall;
	assign pop        = head_valid && (!busy_q || (adv && cur.last));
	assign beat_valid = beat_valid_q;
	assign beat       = beat_q;

	always_comb begin
		istep = lcdseq_pkg::init_step(nib_q);
		if (job_q.kind == lcdseq_pkg::JOB_INIT) begin
			nib       = istep.nib;
			final_nib = (nib_q == lcdseq_pkg::INIT_LAST);
			wcode     = istep.wcode;
		end else begin
			nib       = nib_q[0] ? job_q.data[3:0] : job_q.data[7:4];
			final_nib = nib_q[0];
			wcode     = (nib_q[0] && job_q.slow) ? lcdseq_pkg::WAIT_SLOW : lcdseq_pkg::WAIT_STD;
		end
		base = {nib, job_q.bl, 2'b00, job_q.rs};
		cur  = '{expander_byte: base, wait_after_us: lcdseq_pkg::WAIT_SETUP_US, last: 1'b0};
		if (job_q.kind == lcdseq_pkg::JOB_BL) begin
			// lone backlight beat: only the BL bit
			cur.expander_byte = job_q.bl ? lcdseq_pkg::BIT_BL : 8'h00;
			cur.last          = 1'b1;
		end else begin
			case (phase_q)
				PH_EN_HIGH: begin
					cur.expander_byte = base | lcdseq_pkg::BIT_EN;
					cur.wait_after_us = lcdseq_pkg::WAIT_EN_US;
				end
				PH_EN_LOW: begin
					cur.wait_after_us = lcdseq_pkg::wait_us(wcode);
					cur.last          = final_nib;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			beat_valid_q <= 1'b0;
			beat_q       <= '0;
			job_q        <= '0;
			nib_q        <= '0;
			phase_q      <= PH_SETUP;
		end else begin
			if (adv) begin
				beat_valid_q <= busy_q;
			end
			if (adv && busy_q) begin
				beat_q <= cur;
			end
			if (pop) begin
				busy_q  <= 1'b1;
				job_q   <= head_job;
				nib_q   <= '0;
				phase_q <= PH_SETUP;
			end else if (adv && busy_q) begin
				if (cur.last) begin
					busy_q <= 1'b0;
				end else begin
					unique case (phase_q)
						PH_SETUP:   phase_q <= PH_EN_HIGH;
						PH_EN_HIGH: phase_q <= PH_EN_LOW;
						default: begin
							phase_q <= PH_SETUP;
							nib_q   <= nib_q + 1'b1;
						end
					endcase
				end
			end
		end
	end

endmodule
